/* rtl/hcbd_pkg.sv */
package hcbd_pkg;

    localparam int unsigned SIZE_W    = 36;
    localparam int unsigned STATUS_W  = 3;

    // Queue between the front and the back
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = 2;
    localparam int unsigned Q_CNT_W   = 3;

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;

    localparam logic [STATUS_W-1:0] ST_FRAMING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_item;

    function automatic t_item classify(input logic [7:0] b);
        t_item it;
        it.data    = b;
        it.is_cr   = (b == BYTE_CR);
        it.is_lf   = (b == BYTE_LF);
        it.is_hex  = 1'b0;
        it.hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h37);
        end
        return it;
    endfunction

endpackage

/* rtl/hcbd_front.sv */
module hcbd_front
    import hcbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  [7:0] i_in_byte,
    output logic  o_q_valid,
    input  logic  i_q_pop,
    output t_item o_q_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;
    logic               push;
    logic               pop;

    assign o_ready   = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= classify(i_in_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/hcbd_back.sv */
module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_LINE_MAX = 10
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  t_item               i_q_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [7:0]          o_payload_byte,
    output logic                o_chunk_first
);

    localparam int unsigned CHARS_W = $clog2(SIZE_LINE_MAX);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_SIZE     = 3'd1;
    localparam logic [2:0] PH_AFTER_CR = 3'd2;
    localparam logic [2:0] PH_PAYLOAD  = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    logic [2:0]          r_phase,         n_phase;
    logic [1:0]          r_header_match,  n_header_match;
    logic [SIZE_W-1:0]   r_size_accum,    n_size_accum;
    logic [CHARS_W-1:0]  r_size_chars,    n_size_chars;
    logic                r_digits_closed, n_digits_closed;
    logic [SIZE_W-1:0]   r_bytes_left,    n_bytes_left;
    logic                r_first_pending, n_first_pending;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status,  n_status;
    logic [7:0]          r_payload, n_payload;
    logic                r_first,   n_first;

    logic                pop;
    logic                hdr_hit;

    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;
    // CR expected at even match positions, LF at odd ones
    assign hdr_hit = r_header_match[0] ? i_q_item.is_lf : i_q_item.is_cr;

    always_comb begin
        n_phase         = r_phase;
        n_header_match  = r_header_match;
        n_size_accum    = r_size_accum;
        n_size_chars    = r_size_chars;
        n_digits_closed = r_digits_closed;
        n_bytes_left    = r_bytes_left;
        n_first_pending = r_first_pending;
        n_status        = ST_FRAMING;
        n_payload       = 8'd0;
        n_first         = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (hdr_hit) begin
                    if (r_header_match == 2'd3) begin
                        n_header_match  = 2'd0;
                        n_phase         = PH_SIZE;
                        n_size_accum    = '0;
                        n_size_chars    = '0;
                        n_digits_closed = 1'b0;
                    end else begin
                        n_header_match = r_header_match + 1'b1;
                    end
                end else begin
                    n_header_match = i_q_item.is_cr ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                if (r_size_chars == '0 && (i_q_item.is_cr || i_q_item.is_lf)) begin
                    // skip line breaks ahead of the size line
                end else if (i_q_item.is_cr) begin
                    if (r_size_accum == '0) begin
                        n_status = ST_END;
                        n_phase  = PH_DONE;
                    end else begin
                        n_bytes_left = r_size_accum;
                        n_phase      = PH_AFTER_CR;
                    end
                end else if (r_size_chars >= CHARS_W'(SIZE_LINE_MAX - 1)) begin
                    n_status = ST_ERROR;
                    n_phase  = PH_ERROR;
                end else begin
                    n_size_chars = r_size_chars + 1'b1;
                    if (!r_digits_closed) begin
                        if (!i_q_item.is_hex) begin
                            n_digits_closed = 1'b1;
                        end else begin
                            n_size_accum = {r_size_accum[SIZE_W-5:0], i_q_item.hex_val};
                        end
                    end
                end
            end
            PH_AFTER_CR: begin
                n_phase         = PH_PAYLOAD;
                n_first_pending = 1'b1;
            end
            PH_PAYLOAD: begin
                n_status        = ST_PAYLOAD;
                n_payload       = i_q_item.data;
                n_first         = r_first_pending;
                n_first_pending = 1'b0;
                n_bytes_left    = r_bytes_left - 1'b1;
                if (r_bytes_left == SIZE_W'(1)) begin
                    n_phase         = PH_SIZE;
                    n_size_accum    = '0;
                    n_size_chars    = '0;
                    n_digits_closed = 1'b0;
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEADER;
            r_header_match  <= '0;
            r_size_accum    <= '0;
            r_size_chars    <= '0;
            r_digits_closed <= 1'b0;
            r_bytes_left    <= '0;
            r_first_pending <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (pop) begin
                r_phase         <= n_phase;
                r_header_match  <= n_header_match;
                r_size_accum    <= n_size_accum;
                r_size_chars    <= n_size_chars;
                r_digits_closed <= n_digits_closed;
                r_bytes_left    <= n_bytes_left;
                r_first_pending <= n_first_pending;
                r_out_valid     <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register: load on every transfer from the queue
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_status  <= n_status;
            r_payload <= n_payload;
            r_first   <= n_first;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_payload_byte = r_payload;
    assign o_chunk_first  = r_first;

`ifndef ASSERT_OFF
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("end of body left");

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("error phase left");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_PAYLOAD) |-> (r_payload == 8'd0 && !r_first))
        else $error("non-payload result carries data");

    a_first_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_pending |-> (r_phase == PH_PAYLOAD))
        else $error("chunk start pending outside payload");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_AFTER_CR) |-> (r_bytes_left != '0))
        else $error("payload phase with nothing left");
`endif

endmodule

/* rtl/http_chunked_body_deframer.sv */
// Channel  Handshake            Payload
// in       i_valid / o_ready    i_in_byte
// out      o_valid / i_ready    o_status, o_payload_byte, o_chunk_first
//
// One byte per clock sustained while the output takes results; a byte is written
// into the queue at its input transfer and decoded into the result register when
// the back pops it, and the pop waits while an untaken result is held.
// A four-entry queue lets the input keep flowing while the output stalls.
// Reset is synchronous, active low; it empties the queue and returns to the
// header phase. No clearing pass.
module http_chunked_body_deframer
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_LINE_MAX = 10
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [7:0]          o_payload_byte,
    output logic                o_chunk_first
);

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    hcbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_item  (q_item)
    );

    hcbd_back #(
        .SIZE_LINE_MAX (SIZE_LINE_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_item       (q_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_chunk_first  (o_chunk_first)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hcbd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LINE_MAX     = 10;
    localparam int IDLE_PCT     = 14;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum logic [2:0] {
        PH_HEADER, PH_SIZE, PH_SKIP, PH_DATA, PH_DONE, PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          data;
        logic                first;
    } t_deframed;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [7:0]          i_in_byte = 8'd0;
    logic                i_ready   = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [7:0]          o_payload_byte;
    logic                o_chunk_first;

    // Predictor state
    t_phase      ph         = PH_HEADER;
    logic [1:0]  eoh_count  = '0;
    logic [35:0] size_acc   = '0;
    logic [3:0]  line_chars = '0;
    bit          digits_done;
    logic [35:0] data_left  = '0;
    bit          first_due;

    t_deframed deframed_q[$];
    int        stream_bytes;
    int        mismatches;
    bit        send_gaps = 1'b1;
    bit        recv_gaps = 1'b1;
    int        hold_req;

    http_chunked_body_deframer #(.SIZE_LINE_MAX(LINE_MAX)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_chunk_first  (o_chunk_first)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input int n, input bit upper);
        if (n < 10) return 8'("0" + n);
        return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    // Random byte, never CR; LF and hex digits only where allowed
    function automatic logic [7:0] pick_byte(input bit hex_ok, input bit lf_ok);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == BYTE_CR || (!lf_ok && b == BYTE_LF) || (!hex_ok && hex_digit(b) >= 0));
        return b;
    endfunction

    function automatic void open_size_line();
        ph          = PH_SIZE;
        size_acc    = '0;
        line_chars  = '0;
        digits_done = 1'b0;
    endfunction

    function automatic t_deframed deframe_byte(input logic [7:0] b);
        t_deframed r;
        int        d;
        r = '{status: ST_FRAMING, data: 8'd0, first: 1'b0};
        case (ph)
            PH_HEADER: begin
                if (b == (eoh_count[0] ? BYTE_LF : BYTE_CR)) begin
                    if (eoh_count == 2'd3) begin
                        eoh_count = '0;
                        open_size_line();
                    end else begin
                        eoh_count++;
                    end
                end else begin
                    eoh_count = (b == BYTE_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_SIZE: begin
                if (line_chars == 0 && (b == BYTE_CR || b == BYTE_LF)) begin
                    // skip line breaks ahead of the size line
                end else if (b == BYTE_CR) begin
                    if (size_acc == 0) begin
                        r.status = ST_END;
                        ph       = PH_DONE;
                    end else begin
                        data_left = size_acc;
                        ph        = PH_SKIP;
                    end
                end else if (line_chars >= LINE_MAX - 1) begin
                    r.status = ST_ERROR;
                    ph       = PH_ERROR;
                end else begin
                    d = hex_digit(b);
                    line_chars++;
                    if (!digits_done) begin
                        if (d < 0) digits_done = 1'b1;
                        else size_acc = {size_acc[31:0], 4'(d)};
                    end
                end
            end
            PH_SKIP: begin
                ph        = PH_DATA;
                first_due = 1'b1;
            end
            PH_DATA: begin
                r.status  = ST_PAYLOAD;
                r.data    = b;
                r.first   = first_due;
                first_due = 1'b0;
                data_left--;
                if (data_left == 0) open_size_line();
            end
            default: r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    task automatic offer_byte(input logic [7:0] b);
        while (send_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        deframed_q.push_back(deframe_byte(b));
        stream_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) offer_byte(s[i]);
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i]) offer_byte(q[i]);
    endtask

    task automatic send_random_chunk(input int max_size);
        logic [7:0] line[$];
        int         size;
        int         room;
        size = $urandom_range(1, max_size);
        for (int sh = 28; sh >= 0; sh -= 4) begin
            if ((size >> sh) != 0 || sh == 0)
                line.push_back(hex_char((size >> sh) & 15, 1'($urandom_range(0, 1))));
        end
        room = LINE_MAX - 1 - line.size();
        case ($urandom_range(0, 3))
            1: repeat ($urandom_range(0, room)) line.push_front("0");
            2: if (room > 0) begin
                // extension text: closes the digits, any byte but CR
                line.push_back(pick_byte(1'b0, 1'b1));
                repeat ($urandom_range(0, room - 1)) line.push_back(pick_byte(1'b1, 1'b1));
            end
            default: ;
        endcase
        send_bytes(line);
        offer_byte(BYTE_CR);
        offer_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : BYTE_LF);
        repeat (size) offer_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 5))
            0: ;
            1: repeat ($urandom_range(1, 4))
                offer_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            default: send_text("\015\n");
        endcase
    endtask

    task automatic test_header_scan();
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(1, 10)) offer_byte(pick_byte(1'b1, 1'b0));
            send_text("\015\n");
        end
        // restarts on CR after one and three matched, on other bytes to zero
        send_text("H:\015\015\n\015\015x\015\n\015\015\n\015\n");
    endtask

    task automatic test_size_lines();
        send_text("\015\n\n2;\n\015\015");
        offer_byte(8'h00);
        offer_byte(8'hff);
        send_text("000000001\015\n");
        offer_byte(8'h80);
        send_text("\015\n1g2\015\n");
        offer_byte(8'h7f);
        send_text("\015\n");
    endtask

    task automatic test_random_chunks(input int target);
        while (stream_bytes < target)
            send_random_chunk(($urandom_range(0, 7) == 0) ? 64 : 16);
    endtask

    task automatic test_backpressure();
        int stop_at;
        stop_at   = stream_bytes + 60;
        hold_req  = 80;
        send_gaps = 1'b0;
        while (stream_bytes < stop_at) send_random_chunk(16);
        send_gaps = 1'b1;
    endtask

    task automatic test_body_end();
        int pick;
        int zeros;
        pick = $urandom_range(0, 7);
        if (pick < 3) begin
            zeros = $urandom_range(1, LINE_MAX - 1);
            repeat (zeros) offer_byte("0");
            if (zeros < LINE_MAX - 1) offer_byte(pick_byte(1'b0, 1'b1));
            offer_byte(BYTE_CR);
        end else if (pick < 5) begin
            // line that opens with a non-digit, so the size stays zero
            offer_byte(pick_byte(1'b0, 1'b0));
            repeat ($urandom_range(0, LINE_MAX - 2)) offer_byte(pick_byte(1'b1, 1'b1));
            offer_byte(BYTE_CR);
        end else if (pick < 7) begin
            // too many characters, no CR in time
            offer_byte(pick_byte(1'b1, 1'b0));
            repeat (LINE_MAX - 1) offer_byte(pick_byte(1'b1, 1'b1));
        end else begin
            // largest size the line can hold: payload runs to the end
            send_text("FFFFFFFFF\015\n");
        end
    endtask

    task automatic test_after_end();
        repeat (30) offer_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver: drive ready and check each transfer against the oldest prediction
    initial begin : receiver
        t_deframed exp;
        int        hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    $error("unexpected result: status %0d byte %0h first %0d",
                           o_status, o_payload_byte, o_chunk_first);
                    mismatches++;
                end else begin
                    exp = deframed_q.pop_front();
                    if (o_status !== exp.status) begin
                        $error("status: expected %0d, got %0d", exp.status, o_status);
                        mismatches++;
                    end
                    if (o_payload_byte !== exp.data) begin
                        $error("payload_byte: expected %0h, got %0h", exp.data, o_payload_byte);
                        mismatches++;
                    end
                    if (o_chunk_first !== exp.first) begin
                        $error("chunk_first: expected %0d, got %0d", exp.first, o_chunk_first);
                        mismatches++;
                    end
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(recv_gaps && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_scan();
        test_size_lines();
        test_random_chunks(300);
        // hold both sides steady for a stretch
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        test_random_chunks(420);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_backpressure();
        test_random_chunks(740);
        test_body_end();
        test_after_end();
        i_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
